// File: hdl/shu_pkg.sv
// shared constants, codes and controller/datapath interface types of the histogram unit
`default_nettype none

package shu_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int BAR_SCALE   = 60;

	localparam int CW      = COUNT_WIDTH;
	localparam int NBINS   = 256;
	localparam int ADDR_W  = 8;
	localparam int FRAC_W  = 16;
	localparam int SHARE_W = FRAC_W + 1;
	localparam int BAR_W   = $clog2(BAR_SCALE + 1);
	localparam int PROD_W  = CW + BAR_W;
	localparam int STEP_W  = $clog2(SHARE_W + 1);
	localparam int SYM_W   = 3;
	localparam int OUT_W   = 32;

	typedef enum logic [1:0] {
		REQ_DATA  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	localparam logic [1:0] MODE_BIT  = 2'd0;
	localparam logic [1:0] MODE_NIB  = 2'd1;
	localparam logic [1:0] MODE_BYTE = 2'd2;

	typedef struct packed {
		logic capture;
		logic clear;
		logic sym_rd;
		logic sym_wr;
		logic q_rd;
		logic q_cnt;
		logic bar_start;
		logic bar_take;
		logic share_start;
		logic share_take;
		logic out_load;
	} shu_cmd_t;

	typedef struct packed {
		logic last_sym;
		logic empty;
		logic div_busy;
		logic out_free;
	} shu_sts_t;

endpackage

`default_nettype wire

// File: hdl/shu_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module shu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [shu_pkg::CW-1:0]      rem_init,
	input  logic [shu_pkg::SHARE_W-1:0] num_bits,
	input  logic [shu_pkg::STEP_W-1:0]  steps,
	input  logic [shu_pkg::CW-1:0]      denom,
	output logic                        busy,
	output logic [shu_pkg::SHARE_W-1:0] quotient
);
	import shu_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] steps_q;
	logic [CW-1:0]     rem_q;
	logic [CW-1:0]     den_q;
	logic [SHARE_W-1:0] bits_q;
	logic [SHARE_W-1:0] quo_q;
	logic [CW:0]       trial;
	logic [CW:0]       diff;
	logic              ge;

	assign trial = {rem_q, bits_q[SHARE_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			steps_q <= steps;
		end else if (busy_q) begin
			steps_q <= steps_q - 1'b1;
			busy_q  <= steps_q != STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			den_q  <= denom;
			bits_q <= num_bits;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[CW-1:0] : trial[CW-1:0];
			bits_q <= {bits_q[SHARE_W-2:0], 1'b0};
			quo_q  <= {quo_q[SHARE_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: hdl/shu_dp.sv
// histogram datapath: bin store, counters, divider operands and result register
`default_nettype none

module shu_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  shu_pkg::shu_cmd_t           cmd,
	output shu_pkg::shu_sts_t           sts,
	input  logic                        symbol_mode_we,
	input  logic [1:0]                  symbol_mode_wdata,
	input  logic [7:0]                  data_byte,
	input  logic [7:0]                  bin_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  queried_bin,
	output logic [31:0]                 bin_count,
	output logic [5:0]                  bar_length,
	output logic [16:0]                 share_q16,
	output logic [31:0]                 max_count,
	output logic [31:0]                 total_bytes,
	output logic                        histogram_empty,
	output logic                        index_valid
);
	import shu_pkg::*;

	localparam logic [CW-1:0] CNT_MAX = '1;

	logic [1:0]         mode_q;
	logic [7:0]         byte_sh_q;
	logic [SYM_W-1:0]   sym_left_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [CW-1:0]      max_q;
	logic [CW-1:0]      byte_total_q;
	logic [CW-1:0]      sym_total_q;
	logic [NBINS-1:0]   vld_q;
	logic [CW-1:0]      mem [NBINS];
	logic [CW-1:0]      mem_rd_q;
	logic               vld_rd_q;
	logic [CW-1:0]      cnt_q;
	logic [BAR_W-1:0]   bar_q;
	logic [SHARE_W-1:0] share_q;
	logic               out_valid_q;

	logic [ADDR_W-1:0]  sym_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [CW-1:0]      bin_cur;
	logic [CW-1:0]      bin_inc;
	logic               idx_ok;
	logic [SYM_W-1:0]   sym_init;
	logic [7:0]         byte_next;
	logic [PROD_W-1:0]  prod;
	logic [CW-1:0]      div_rem;
	logic [SHARE_W-1:0] div_bits;
	logic [STEP_W-1:0]  div_steps;
	logic [CW-1:0]      div_den;
	logic               div_busy;
	logic [SHARE_W-1:0] div_quo;

	always_comb begin
		case (mode_q)
			MODE_BIT: begin
				sym_addr  = {7'd0, byte_sh_q[0]};
				idx_ok    = idx_q[7:1] == 7'd0;
				sym_init  = SYM_W'(7);
				byte_next = {1'b0, byte_sh_q[7:1]};
			end
			MODE_NIB: begin
				sym_addr  = {4'd0, byte_sh_q[3:0]};
				idx_ok    = idx_q[7:4] == 4'd0;
				sym_init  = SYM_W'(1);
				byte_next = {4'd0, byte_sh_q[7:4]};
			end
			default: begin
				sym_addr  = byte_sh_q;
				idx_ok    = 1'b1;
				sym_init  = '0;
				byte_next = byte_sh_q;
			end
		endcase
	end

	assign rd_addr = cmd.q_rd ? idx_q : sym_addr;
	assign bin_cur = vld_rd_q ? mem_rd_q : '0;
	assign bin_inc = (bin_cur == CNT_MAX) ? bin_cur : bin_cur + 1'b1;
	assign prod    = PROD_W'(cnt_q) * PROD_W'(BAR_SCALE);

	always_comb begin
		if (cmd.bar_start) begin
			div_rem   = prod[PROD_W-1:BAR_W];
			div_bits  = {prod[BAR_W-1:0], {(SHARE_W-BAR_W){1'b0}}};
			div_steps = STEP_W'(BAR_W);
			div_den   = max_q;
		end else begin
			div_rem   = cnt_q >> 1;
			div_bits  = {cnt_q[0], {FRAC_W{1'b0}}};
			div_steps = STEP_W'(SHARE_W);
			div_den   = sym_total_q;
		end
	end

	shu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.bar_start | cmd.share_start),
		.rem_init (div_rem),
		.num_bits (div_bits),
		.steps    (div_steps),
		.denom    (div_den),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_BYTE;
			vld_q        <= '0;
			max_q        <= '0;
			byte_total_q <= '0;
			sym_total_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (symbol_mode_we) begin
				mode_q <= symbol_mode_wdata;
			end
			if (cmd.clear) begin
				vld_q        <= '0;
				max_q        <= '0;
				byte_total_q <= '0;
				sym_total_q  <= '0;
			end else if (cmd.sym_wr) begin
				vld_q[sym_addr] <= 1'b1;
				if (bin_inc > max_q) begin
					max_q <= bin_inc;
				end
				if (sym_total_q != CNT_MAX) begin
					sym_total_q <= sym_total_q + 1'b1;
				end
				if (sym_left_q == '0 && byte_total_q != CNT_MAX) begin
					byte_total_q <= byte_total_q + 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// bin store
	always_ff @(posedge clk) begin
		if (cmd.sym_wr) begin
			mem[sym_addr] <= bin_inc;
		end
		if (cmd.sym_rd | cmd.q_rd) begin
			mem_rd_q <= mem[rd_addr];
			vld_rd_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_sh_q  <= data_byte;
			sym_left_q <= sym_init;
			idx_q      <= bin_index;
		end else if (cmd.sym_wr) begin
			byte_sh_q  <= byte_next;
			sym_left_q <= sym_left_q - 1'b1;
		end
		if (cmd.q_cnt) begin
			cnt_q   <= idx_ok ? bin_cur : '0;
			bar_q   <= '0;
			share_q <= '0;
		end
		if (cmd.bar_take) begin
			bar_q <= div_quo[BAR_W-1:0];
		end
		if (cmd.share_take) begin
			share_q <= div_quo;
		end
		if (cmd.out_load) begin
			queried_bin     <= idx_q;
			bin_count       <= OUT_W'(cnt_q);
			bar_length      <= 6'(bar_q);
			share_q16       <= share_q;
			max_count       <= OUT_W'(max_q);
			total_bytes     <= OUT_W'(byte_total_q);
			histogram_empty <= max_q == '0;
			index_valid     <= idx_ok;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.last_sym = sym_left_q == '0;
	assign sts.empty    = max_q == '0;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_valid_q || out_ready;

`ifndef SYNTH
	a_empty_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(max_q == '0) == (sym_total_q == '0))
		else $error("max count and symbol total disagree on emptiness");
	a_bar_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bar_take |=> bar_q <= BAR_W'(BAR_SCALE))
		else $error("bar length above scale");
	a_share_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.share_take |=> share_q <= SHARE_W'(1 << FRAC_W))
		else $error("share above one");
`endif

endmodule

`default_nettype wire

// File: hdl/shu_ctrl.sv
// histogram controller: sequences symbol updates, queries and result handoff
`default_nettype none

module shu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  shu_pkg::shu_sts_t sts,
	output shu_pkg::shu_cmd_t cmd
);
	import shu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SYM_RD,
		S_SYM_WR,
		S_Q_RD,
		S_Q_CNT,
		S_BAR_GO,
		S_BAR_RUN,
		S_SHR_GO,
		S_SHR_RUN,
		S_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (req_type)
							REQ_DATA:  state_q <= S_SYM_RD;
							REQ_QUERY: state_q <= S_Q_RD;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_SYM_RD:  state_q <= S_SYM_WR;
				S_SYM_WR:  state_q <= sts.last_sym ? S_IDLE : S_SYM_RD;
				S_Q_RD:    state_q <= S_Q_CNT;
				S_Q_CNT:   state_q <= sts.empty ? S_DONE : S_BAR_GO;
				S_BAR_GO:  state_q <= S_BAR_RUN;
				S_BAR_RUN: begin
					if (!sts.div_busy) begin
						state_q <= S_SHR_GO;
					end
				end
				S_SHR_GO:  state_q <= S_SHR_RUN;
				S_SHR_RUN: begin
					if (!sts.div_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd             = '0;
		cmd.capture     = in_ready && in_valid;
		cmd.clear       = in_ready && in_valid && req_type == REQ_CLEAR;
		cmd.sym_rd      = state_q == S_SYM_RD;
		cmd.sym_wr      = state_q == S_SYM_WR;
		cmd.q_rd        = state_q == S_Q_RD;
		cmd.q_cnt       = state_q == S_Q_CNT;
		cmd.bar_start   = state_q == S_BAR_GO;
		cmd.bar_take    = state_q == S_BAR_RUN && !sts.div_busy;
		cmd.share_start = state_q == S_SHR_GO;
		cmd.share_take  = state_q == S_SHR_RUN && !sts.div_busy;
		cmd.out_load    = state_q == S_DONE && sts.out_free;
	end

`ifndef SYNTH
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.div_busy)
		else $error("divider busy while idle");
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.bar_start || cmd.share_start) |-> (!sts.empty && !sts.div_busy))
		else $error("divider started on empty histogram or while busy");
	a_rmw_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sym_wr |-> $past(cmd.sym_rd))
		else $error("bin write without preceding read");
`endif

endmodule

`default_nettype wire

// File: hdl/symbol_histogram_unit.sv
// symbol histogram unit top level: controller and datapath
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------
//  config    | symbol_mode_we        | symbol_mode_wdata
//  input     | in_valid / in_ready   | req_type, data_byte, bin_index
//  output    | out_valid / out_ready | queried_bin ... index_valid
//
// data byte: split into one, two or eight symbols for 8-, 4- or 1-bit symbols,
//   one read and one write of the bin memory per symbol
// query: the bit-serial divider forms a 6-bit bar length, then a 17-bit share;
//   the divider is skipped when the histogram is empty. clear: acts on acceptance
// reset clears all bins at once through per-bin valid bits; no sweep
// a query waits in its last cycle while the previous result is not taken
`default_nettype none

module symbol_histogram_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        symbol_mode_we,
	input  logic [1:0]  symbol_mode_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  bin_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  queried_bin,
	output logic [31:0] bin_count,
	output logic [5:0]  bar_length,
	output logic [16:0] share_q16,
	output logic [31:0] max_count,
	output logic [31:0] total_bytes,
	output logic        histogram_empty,
	output logic        index_valid
);
	import shu_pkg::*;

	shu_cmd_t cmd;
	shu_sts_t sts;

	shu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	shu_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.symbol_mode_we    (symbol_mode_we),
		.symbol_mode_wdata (symbol_mode_wdata),
		.data_byte         (data_byte),
		.bin_index         (bin_index),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.queried_bin       (queried_bin),
		.bin_count         (bin_count),
		.bar_length        (bar_length),
		.share_q16         (share_q16),
		.max_count         (max_count),
		.total_bytes       (total_bytes),
		.histogram_empty   (histogram_empty),
		.index_valid       (index_valid)
	);

endmodule

`default_nettype wire
